// ===== hdl/bfpa_pkg.sv =====
// Shared types and constants for the best-fit page allocator.
`timescale 1ns / 1ps

package bfpa_pkg;

    localparam int ADDR_W   = 48;
    localparam int PAGES_W  = 32;
    localparam int CFG_W    = 5;
    localparam int ENTRY_W  = 4;
    localparam int REGION_W = 4;
    localparam int LOW_W    = 32;

    typedef enum logic [1:0] {
        STATUS_ALLOC   = 2'd0,
        STATUS_NOFIT   = 2'd1,
        STATUS_WRITTEN = 2'd2
    } status_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_ALLOC = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] total;
        logic [PAGES_W-1:0] used;
        logic               persistent;
        logic               special;
    } region_t;

    typedef struct packed {
        logic               stop;
        logic               better;
        logic [PAGES_W-1:0] gap;
    } eval_t;

    typedef struct packed {
        logic                fire;
        status_t             status;
        logic [ADDR_W-1:0]   addr;
        logic [REGION_W-1:0] region;
    } result_t;

endpackage

// ===== hdl/bfpa_table.sv =====
// Region table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bfpa_table #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic               clk,
    input  logic               we,
    input  logic [IDX_W-1:0]   waddr,
    input  bfpa_pkg::region_t  wdata,
    input  logic [IDX_W-1:0]   raddr,
    output bfpa_pkg::region_t  rdata
);

    bfpa_pkg::region_t mem [DEPTH];
    bfpa_pkg::region_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bfpa_eval.sv =====
// Shared fit unit: free pages, leftover and best-so-far compare for one entry.
`timescale 1ns / 1ps

module bfpa_eval (
    input  bfpa_pkg::region_t                 entry,
    input  logic [bfpa_pkg::PAGES_W-1:0]      want,
    input  logic                              low,
    input  logic                              found,
    input  logic [bfpa_pkg::PAGES_W-1:0]      best_gap,
    output bfpa_pkg::eval_t                   result
);

    logic [bfpa_pkg::PAGES_W-1:0] avail;
    logic [bfpa_pkg::PAGES_W-1:0] gap;
    logic                         fits;
    logic                         low_stop;
    logic                         usable;

    always_comb
    begin
        // used above total counts as no free pages
        avail    = (entry.used > entry.total) ? '0 : entry.total - entry.used;
        fits     = (avail >= want);
        gap      = avail - want;
        low_stop = low && (|entry.base[bfpa_pkg::ADDR_W-1:bfpa_pkg::LOW_W]);
        usable   = !entry.persistent && !entry.special && fits;

        result.stop   = low_stop;
        result.better = !low_stop && usable && (!found || (gap < best_gap));
        result.gap    = gap;
    end

endmodule

// ===== hdl/bfpa_seq.sv =====
// Sequencer: write handling, table scan, best tracking and write-back.
`timescale 1ns / 1ps

module bfpa_seq #(
    parameter int REGIONS    = 16,
    parameter int PAGE_BYTES = 4096,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               op,
    input  logic [bfpa_pkg::ENTRY_W-1:0]       entry_index,
    input  bfpa_pkg::region_t                  entry_in,
    input  logic [bfpa_pkg::PAGES_W-1:0]       page_count,
    input  logic                               low_only,
    input  logic [bfpa_pkg::CFG_W-1:0]         region_count,
    output logic                               busy,
    // table ports
    output logic                               mem_we,
    output logic [IDX_W-1:0]                   mem_waddr,
    output bfpa_pkg::region_t                  mem_wdata,
    output logic [IDX_W-1:0]                   mem_raddr,
    input  bfpa_pkg::region_t                  mem_rdata,
    // fit unit
    output logic [bfpa_pkg::PAGES_W-1:0]       ev_want,
    output logic                               ev_low,
    output logic                               ev_found,
    output logic [bfpa_pkg::PAGES_W-1:0]       ev_best_gap,
    input  bfpa_pkg::eval_t                    ev_result,
    output bfpa_pkg::result_t                  result
);

    localparam logic [bfpa_pkg::ADDR_W-1:0] PAGE_MULT = bfpa_pkg::ADDR_W'(PAGE_BYTES);

    bfpa_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]             ptr_reg, ptr_next;
    logic [CNT_W-1:0]             limit_reg, limit_next;
    logic [IDX_W-1:0]             eval_idx_reg, eval_idx_next;
    logic                         pend_reg, pend_next;
    logic                         stop_reg, stop_next;
    logic                         found_reg, found_next;
    logic [IDX_W-1:0]             best_idx_reg, best_idx_next;
    logic [bfpa_pkg::PAGES_W-1:0] best_gap_reg, best_gap_next;
    bfpa_pkg::region_t            best_reg, best_next;
    logic [bfpa_pkg::PAGES_W-1:0] want_reg, want_next;
    logic                         low_reg, low_next;
    logic [bfpa_pkg::ADDR_W-1:0]  prod_reg, prod_next;

    logic                         issue;
    logic                         idx_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfpa_pkg::S_IDLE;
            pend_reg  <= 1'b0;
            stop_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            stop_reg  <= stop_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        limit_reg    <= limit_next;
        eval_idx_reg <= eval_idx_next;
        best_idx_reg <= best_idx_next;
        best_gap_reg <= best_gap_next;
        best_reg     <= best_next;
        want_reg     <= want_next;
        low_reg      <= low_next;
        prod_reg     <= prod_next;
    end

    assign ev_want     = want_reg;
    assign ev_low      = low_reg;
    assign ev_found    = found_reg;
    assign ev_best_gap = best_gap_reg;
    assign mem_raddr   = ptr_reg[IDX_W-1:0];
    assign busy        = (state_reg != bfpa_pkg::S_IDLE);
    assign idx_ok      = (32'(entry_index) < REGIONS);

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        limit_next    = limit_reg;
        eval_idx_next = eval_idx_reg;
        pend_next     = 1'b0;
        stop_next     = stop_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_gap_next = best_gap_reg;
        best_next     = best_reg;
        want_next     = want_reg;
        low_next      = low_reg;
        prod_next     = prod_reg;
        issue         = 1'b0;

        mem_we    = 1'b0;
        mem_waddr = IDX_W'(entry_index);
        mem_wdata = entry_in;

        result.fire   = 1'b0;
        result.status = bfpa_pkg::STATUS_NOFIT;
        result.addr   = '0;
        result.region = '0;

        unique case (state_reg)
            bfpa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (op == bfpa_pkg::OP_WRITE)
                    begin
                        mem_we        = idx_ok;
                        result.fire   = 1'b1;
                        result.status = bfpa_pkg::STATUS_WRITTEN;
                    end
                    else
                    begin
                        want_next  = page_count;
                        low_next   = low_only;
                        limit_next = (32'(region_count) > REGIONS) ?
                                     CNT_W'(REGIONS) : CNT_W'(region_count);
                        ptr_next   = '0;
                        stop_next  = 1'b0;
                        found_next = 1'b0;
                        state_next = bfpa_pkg::S_SCAN;
                    end
                end
            end

            bfpa_pkg::S_SCAN:
            begin
                // read entry ptr this cycle, judge it the next
                issue = (ptr_reg < limit_reg) && !stop_reg;
                if (issue)
                begin
                    pend_next     = 1'b1;
                    eval_idx_next = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + 1'b1;
                end

                if (pend_reg && !stop_reg)
                begin
                    if (ev_result.stop)
                    begin
                        stop_next = 1'b1;
                    end
                    else if (ev_result.better)
                    begin
                        found_next    = 1'b1;
                        best_idx_next = eval_idx_reg;
                        best_gap_next = ev_result.gap;
                        best_next     = mem_rdata;
                    end
                end

                if (!issue && !pend_reg)
                begin
                    if (found_reg)
                    begin
                        state_next = bfpa_pkg::S_MUL;
                    end
                    else
                    begin
                        result.fire   = 1'b1;
                        result.status = bfpa_pkg::STATUS_NOFIT;
                        state_next    = bfpa_pkg::S_IDLE;
                    end
                end
            end

            bfpa_pkg::S_MUL:
            begin
                prod_next  = bfpa_pkg::ADDR_W'(best_reg.used) * PAGE_MULT;
                state_next = bfpa_pkg::S_DONE;
            end

            bfpa_pkg::S_DONE:
            begin
                mem_we         = 1'b1;
                mem_waddr      = best_idx_reg;
                mem_wdata      = best_reg;
                mem_wdata.used = best_reg.used + want_reg;
                result.fire    = 1'b1;
                result.status  = bfpa_pkg::STATUS_ALLOC;
                result.addr    = best_reg.base + prod_reg;
                result.region  = bfpa_pkg::REGION_W'(best_idx_reg);
                state_next     = bfpa_pkg::S_IDLE;
            end

            default:
            begin
                state_next = bfpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/best_fit_page_allocator.sv =====
// Top level of the best-fit page allocator.
//
// Usage: a command channel (start/busy) takes one item when start is high
// and busy is low. op selects a table write or a page allocation. Every item
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall it, so it must take it in that cycle.
// A write item loads one region entry (an index past the table is dropped)
// and answers status "written" on the cycle after it is taken; busy stays low,
// so writes can be issued back to back.
// An allocation scans entries 0 .. min(region_count, REGIONS)-1 through the
// region memory, one entry a cycle; the shared fit unit judges each entry
// in the cycle after its read. The low memory limit can end the scan early.
// When nothing fits, the result shows once the scan ends; when a region is
// chosen, state S_MUL forms the page offset and S_DONE writes the entry
// back and gives the result. The read port and one fit unit set the pace.
// busy is high from the cycle after an allocation is taken until its result
// is shown. region_count is to be written through cfg_we/cfg_wdata while
// idle; the block does not enforce this. Reset clears region_count and the
// control state; the region table holds garbage until written.
`timescale 1ns / 1ps

module best_fit_page_allocator #(
    parameter int REGIONS    = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              op,
    input  logic [bfpa_pkg::ENTRY_W-1:0]      entry_index,
    input  logic [bfpa_pkg::ADDR_W-1:0]       entry_base,
    input  logic [bfpa_pkg::PAGES_W-1:0]      entry_total_pages,
    input  logic [bfpa_pkg::PAGES_W-1:0]      entry_used_pages,
    input  logic                              entry_persistent,
    input  logic                              entry_special,
    input  logic [bfpa_pkg::PAGES_W-1:0]      page_count,
    input  logic                              low_only,
    // region_count register
    input  logic                              cfg_we,
    input  logic [bfpa_pkg::CFG_W-1:0]        cfg_wdata,
    // result channel
    output logic                              done,
    output logic [1:0]                        status,
    output logic [bfpa_pkg::ADDR_W-1:0]       alloc_address,
    output logic [bfpa_pkg::REGION_W-1:0]     chosen_region
);

    localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CNT_W = $clog2(REGIONS + 1);

    logic [bfpa_pkg::CFG_W-1:0]    region_count_reg;
    logic                          done_reg;
    bfpa_pkg::status_t             status_reg;
    logic [bfpa_pkg::ADDR_W-1:0]   addr_reg;
    logic [bfpa_pkg::REGION_W-1:0] region_reg;

    bfpa_pkg::region_t             entry_in;
    bfpa_pkg::result_t             result;

    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    bfpa_pkg::region_t             mem_wdata;
    logic [IDX_W-1:0]              mem_raddr;
    bfpa_pkg::region_t             mem_rdata;

    logic [bfpa_pkg::PAGES_W-1:0]  ev_want;
    logic                          ev_low;
    logic                          ev_found;
    logic [bfpa_pkg::PAGES_W-1:0]  ev_best_gap;
    bfpa_pkg::eval_t               ev_result;
    logic                          seq_busy;

    always_comb
    begin
        entry_in.base       = entry_base;
        entry_in.total      = entry_total_pages;
        entry_in.used       = entry_used_pages;
        entry_in.persistent = entry_persistent;
        entry_in.special    = entry_special;
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            region_count_reg <= cfg_wdata;
        end
    end

    // result register: one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= result.fire;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= result.status;
        addr_reg   <= result.addr;
        region_reg <= result.region;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign alloc_address = addr_reg;
    assign chosen_region = region_reg;
    assign busy          = seq_busy;

    bfpa_table #(
        .DEPTH (REGIONS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bfpa_eval u_eval (
        .entry    (mem_rdata),
        .want     (ev_want),
        .low      (ev_low),
        .found    (ev_found),
        .best_gap (ev_best_gap),
        .result   (ev_result)
    );

    bfpa_seq #(
        .REGIONS    (REGIONS),
        .PAGE_BYTES (PAGE_BYTES),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .entry_index  (entry_index),
        .entry_in     (entry_in),
        .page_count   (page_count),
        .low_only     (low_only),
        .region_count (region_count_reg),
        .busy         (seq_busy),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .ev_want      (ev_want),
        .ev_low       (ev_low),
        .ev_found     (ev_found),
        .ev_best_gap  (ev_best_gap),
        .ev_result    (ev_result),
        .result       (result)
    );

endmodule

// ===== hdl/bfpa_chk.sv =====
// Port-level checker for the best-fit page allocator, bound to the top level.
`timescale 1ns / 1ps

module bfpa_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              op,
    input logic                              done,
    input logic [1:0]                        status,
    input logic [bfpa_pkg::ADDR_W-1:0]       alloc_address,
    input logic [bfpa_pkg::REGION_W-1:0]     chosen_region
);

    // a taken write answers "written" on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == bfpa_pkg::OP_WRITE) |=>
            (done && status == bfpa_pkg::STATUS_WRITTEN))
        else $error("write item not answered on next cycle");

    // a taken allocation holds busy and gives no result the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == bfpa_pkg::OP_ALLOC) |=> (busy && !done))
        else $error("allocation did not hold busy");

    // an allocation ends with its result as busy drops
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (done && status != bfpa_pkg::STATUS_WRITTEN))
        else $error("busy dropped without an allocation result");

    // no address or region unless allocated
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != bfpa_pkg::STATUS_ALLOC) |->
            (alloc_address == '0 && chosen_region == '0))
        else $error("address or region set on a non-allocation result");

endmodule

bind best_fit_page_allocator bfpa_chk u_bfpa_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .done          (done),
    .status        (status),
    .alloc_address (alloc_address),
    .chosen_region (chosen_region)
);
